// ===== src/afmt_pkg.sv =====
// Package for the AX.25 frame to monitor text block.
// Holds the channel word types, character constants and callsign helpers.
// No dependencies.
package afmt_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       line_end;
    logic       drop_line;
  } out_t;

  localparam logic [3:0] KissTypeMask = 4'hF;
  localparam logic [7:0] CtrlUi       = 8'h03;
  localparam logic [7:0] PidNone      = 8'hF0;
  localparam logic [7:0] ChCr         = 8'h0D;
  localparam logic [7:0] ChLf         = 8'h0A;
  localparam logic [7:0] ChSpace      = 8'h20;
  localparam logic [7:0] ChTilde      = 8'h7E;
  localparam logic [7:0] ChGt         = 8'h3E;
  localparam logic [7:0] ChColon      = 8'h3A;
  localparam logic [7:0] ChComma      = 8'h2C;
  localparam logic [7:0] ChStar       = 8'h2A;
  localparam logic [7:0] ChDash       = 8'h2D;
  localparam logic [7:0] ChZero       = 8'h30;
  localparam logic [7:0] ChOne        = 8'h31;
  localparam logic [2:0] AddrLastByte = 3'd6;
  localparam logic [3:0] InvLastPos   = 4'd8;

  // Letter, digit or space after the address shift
  function automatic logic call_char_ok(input logic [6:0] c);
    logic ok;
    ok = (c >= 7'h30 && c <= 7'h39) || (c >= 7'h41 && c <= 7'h5A) ||
         (c >= 7'h61 && c <= 7'h7A) || (c == 7'h20);
    return ok;
  endfunction

  // Text for a callsign with a bad character
  function automatic logic [7:0] invalid_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h5B;
      4'd1:    c = 8'h69;
      4'd2:    c = 8'h6E;
      4'd3:    c = 8'h76;
      4'd4:    c = 8'h61;
      4'd5:    c = 8'h6C;
      4'd6:    c = 8'h69;
      4'd7:    c = 8'h64;
      default: c = 8'h5D;
    endcase
    return c;
  endfunction

endpackage

// ===== src/ax25_frame_to_monitor_text.sv =====
// Top level of the AX.25 frame to monitor text block.
// Depends on afmt_pkg for word types, constants and callsign helpers.
//
// Usage:
//   The input channel takes one frame byte per word, the KISS type byte
//   first, with frame_end set on the last byte. The output channel gives
//   one character of the monitor line per word, SOURCE>DEST,DIGI*:info
//   then CR LF; line_end marks the LF. A rejected frame ends in a word
//   with drop_line and line_end set: discard the partial line.
//   Throughput: KISS, control and most address bytes are taken one per
//   cycle, and info and PID bytes push their character in the accept
//   cycle, one per cycle, while the sink keeps up. The seventh byte of an
//   address starts a text burst that holds off the input: a callsign
//   steps through the comma slot, a read and a check of each address
//   character (spaces included) and the dash and SSID characters, or
//   the invalid text instead, then the star slot; '>', CR and LF are
//   items of their own. Latency: info, PID and drop words appear the
//   cycle after their byte is accepted; a burst's characters come after
//   the registered job and, for an address character, its memory read.
//   Reset clears all control state; the address memory needs no clearing.
//   When the sink stalls, the output register holds its word and the
//   input is not taken until that word can be replaced.
module ax25_frame_to_monitor_text #(
  parameter int unsigned MAX_DIGIS = 6
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  afmt_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output afmt_pkg::out_t out_data_o
);
  import afmt_pkg::*;

  typedef enum logic [2:0] {
    PH_KISS, PH_ADDR, PH_CTRL, PH_PID, PH_INFO
  } phase_e;

  typedef enum logic [2:0] {
    C_START, C_INV, C_RD, C_CHK, C_DASH, C_TEN, C_ONE, C_STAR
  } call_e;

  // Burst items, bit order is emit order
  localparam int ItA  = 0;
  localparam int ItGt = 1;
  localparam int ItB  = 2;
  localparam int ItCr = 3;
  localparam int ItLf = 4;

  // Control state
  phase_e     phase_q, phase_d;
  logic [2:0] bia_q, bia_d;
  logic [3:0] anum_q, anum_d;
  logic       pvalid_q, pvalid_d;
  logic       rej_q, rej_d;
  logic [1:0] dst_p_q, dst_p_d, cur_p_q, cur_p_d, pnd_p_q, pnd_p_d;

  // Address metadata by role
  logic       c_bad_q, c_nsp_q;
  logic       d_bad_q;
  logic [3:0] d_ssid_q;
  logic       p_bad_q, p_nsp_q, p_h_q;
  logic [3:0] p_ssid_q;

  // Burst job
  logic [4:0] todo_q, todo_d;
  logic [1:0] ja_slot_q, jb_slot_q;
  logic       ja_bad_q, jb_bad_q, ja_comma_q, jb_comma_q, ja_star_q, jb_star_q;
  logic [3:0] ja_ssid_q, jb_ssid_q;
  logic [1:0] ja_slot_d, jb_slot_d;
  logic       ja_bad_d, jb_bad_d, ja_comma_d, jb_comma_d, ja_star_d, jb_star_d;
  logic [3:0] ja_ssid_d, jb_ssid_d;

  call_e      sub_q, sub_d;
  logic [3:0] pos_q, pos_d;

  // Address memory: three slots of eight bytes
  logic [7:0] mem_q [24];
  logic [7:0] rdata_q;
  logic [4:0] rd_addr;
  logic       rd_en;

  // Output register
  logic       ov_q;
  out_t       out_q;

  logic       can_push, idle, accept;
  logic [6:0] in_c;
  logic       last, empty_cur, empty_pnd, cur_h;
  logic [3:0] new_ssid;
  logic       a_push;
  out_t       a_word;
  logic       a_wr;
  logic       rej, done;

  assign can_push    = !ov_q || out_ready_i;
  assign idle        = (todo_q == '0);
  assign in_ready_o  = idle && can_push;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  assign in_c      = in_data_i.data_byte[7:1];
  assign last      = in_data_i.data_byte[0];
  assign cur_h     = in_data_i.data_byte[7];
  assign new_ssid  = in_data_i.data_byte[4:1];
  assign empty_cur = !c_bad_q && !c_nsp_q && (new_ssid == 4'd0);
  assign empty_pnd = !p_bad_q && !p_nsp_q && (p_ssid_q == 4'd0);

  // Decide the step for an accepted byte
  always_comb begin
    phase_d    = phase_q;
    bia_d      = bia_q;
    anum_d     = anum_q;
    pvalid_d   = pvalid_q;
    rej_d      = rej_q;
    dst_p_d    = dst_p_q;
    cur_p_d    = cur_p_q;
    pnd_p_d    = pnd_p_q;
    todo_d     = '0;
    ja_slot_d  = ja_slot_q;
    jb_slot_d  = jb_slot_q;
    ja_bad_d   = ja_bad_q;
    jb_bad_d   = jb_bad_q;
    ja_ssid_d  = ja_ssid_q;
    jb_ssid_d  = jb_ssid_q;
    ja_comma_d = ja_comma_q;
    jb_comma_d = jb_comma_q;
    ja_star_d  = ja_star_q;
    jb_star_d  = jb_star_q;
    a_push     = 1'b0;
    a_word     = '0;
    a_wr       = 1'b0;
    rej        = 1'b0;
    done       = 1'b0;
    if (rej_q) begin
      if (in_data_i.frame_end) begin
        rej_d   = 1'b0;
        phase_d = PH_KISS;
      end
    end else begin
      case (phase_q)
        PH_ADDR: begin
          a_wr = 1'b1;
          if (bia_q != AddrLastByte) begin
            bia_d = bia_q + 3'd1;
          end else begin
            bia_d = '0;
            if (anum_q == 4'd0) begin
              dst_p_d = cur_p_q;
              cur_p_d = dst_p_q;
              anum_d  = 4'd1;
            end else if (anum_q == 4'd1) begin
              if (!last && MAX_DIGIS == 0) begin
                rej = 1'b1;
              end else begin
                todo_d[ItA]  = 1'b1;
                todo_d[ItGt] = 1'b1;
                todo_d[ItB]  = 1'b1;
                ja_slot_d  = cur_p_q;
                ja_bad_d   = c_bad_q;
                ja_ssid_d  = new_ssid;
                ja_comma_d = 1'b0;
                ja_star_d  = 1'b0;
                jb_slot_d  = dst_p_q;
                jb_bad_d   = d_bad_q;
                jb_ssid_d  = d_ssid_q;
                jb_comma_d = 1'b0;
                jb_star_d  = 1'b0;
                if (last) phase_d = PH_CTRL;
                else anum_d = 4'd2;
              end
            end else begin
              if (!last && (int'(anum_q) - 1 >= int'(MAX_DIGIS))) begin
                rej = 1'b1;
              end else begin
                todo_d[ItA] = pvalid_q && !empty_pnd;
                ja_slot_d  = pnd_p_q;
                ja_bad_d   = p_bad_q;
                ja_ssid_d  = p_ssid_q;
                ja_comma_d = 1'b1;
                ja_star_d  = p_h_q && !cur_h;
                if (last) begin
                  todo_d[ItB] = !empty_cur;
                  jb_slot_d  = cur_p_q;
                  jb_bad_d   = c_bad_q;
                  jb_ssid_d  = new_ssid;
                  jb_comma_d = 1'b1;
                  jb_star_d  = cur_h;
                  pvalid_d   = 1'b0;
                  phase_d    = PH_CTRL;
                end else begin
                  pnd_p_d  = cur_p_q;
                  cur_p_d  = pnd_p_q;
                  pvalid_d = 1'b1;
                  anum_d   = anum_q + 4'd1;
                end
              end
            end
          end
        end
        PH_CTRL: begin
          if (in_data_i.data_byte != CtrlUi) rej = 1'b1;
          else phase_d = PH_PID;
        end
        PH_PID: begin
          if (in_data_i.data_byte != PidNone) begin
            rej = 1'b1;
          end else begin
            a_push          = 1'b1;
            a_word.out_char = ChColon;
            phase_d         = PH_INFO;
            done            = in_data_i.frame_end;
          end
        end
        PH_INFO: begin
          a_push          = 1'b1;
          a_word.out_char = (in_data_i.data_byte >= ChSpace &&
                             in_data_i.data_byte <= ChTilde) ?
                            in_data_i.data_byte : ChSpace;
          done            = in_data_i.frame_end;
        end
        default: begin
          if ((in_data_i.data_byte[3:0] & KissTypeMask) != 4'd0) begin
            rej = 1'b1;
          end else begin
            phase_d  = PH_ADDR;
            bia_d    = '0;
            anum_d   = '0;
            pvalid_d = 1'b0;
          end
        end
      endcase
      if (in_data_i.frame_end && !done) rej = 1'b1;
      if (rej) begin
        todo_d           = '0;
        a_push           = 1'b1;
        a_word           = '0;
        a_word.line_end  = 1'b1;
        a_word.drop_line = 1'b1;
        pvalid_d         = 1'b0;
        bia_d            = '0;
        anum_d           = '0;
        phase_d          = PH_KISS;
        rej_d            = !in_data_i.frame_end;
      end else if (done) begin
        todo_d[ItCr] = 1'b1;
        todo_d[ItLf] = 1'b1;
        phase_d      = PH_KISS;
        bia_d        = '0;
        anum_d       = '0;
        pvalid_d     = 1'b0;
      end
    end
  end

  // Burst sequencer: walk the pending items, one callsign unit
  logic [4:0] low_bit;
  logic       sq_push, sq_le, it_done, is_a, is_call;
  logic [7:0] sq_char;
  logic       cs_bad, cs_comma, cs_star;
  logic [3:0] cs_ssid;
  logic [1:0] cs_slot;
  logic [6:0] rd_c;
  logic [3:0] ones;

  assign low_bit  = todo_q & (~todo_q + 5'd1);
  assign is_a     = low_bit[ItA];
  assign is_call  = low_bit[ItA] || low_bit[ItB];
  assign cs_bad   = is_a ? ja_bad_q : jb_bad_q;
  assign cs_comma = is_a ? ja_comma_q : jb_comma_q;
  assign cs_star  = is_a ? ja_star_q : jb_star_q;
  assign cs_ssid  = is_a ? ja_ssid_q : jb_ssid_q;
  assign cs_slot  = is_a ? ja_slot_q : jb_slot_q;
  assign rd_c     = rdata_q[7:1];
  assign ones     = (cs_ssid >= 4'd10) ? cs_ssid - 4'd10 : cs_ssid;
  assign rd_addr  = {cs_slot, pos_q[2:0]};

  always_comb begin
    sq_push = 1'b0;
    sq_le   = 1'b0;
    sq_char = '0;
    it_done = 1'b0;
    sub_d   = sub_q;
    pos_d   = pos_q;
    rd_en   = 1'b0;
    if (!idle) begin
      if (!is_call) begin
        sq_push = 1'b1;
        sq_char = low_bit[ItGt] ? ChGt : (low_bit[ItCr] ? ChCr : ChLf);
        sq_le   = low_bit[ItLf];
        it_done = can_push;
      end else begin
        case (sub_q)
          C_START: begin
            sq_push = cs_comma;
            sq_char = ChComma;
            if (!cs_comma || can_push) begin
              sub_d = cs_bad ? C_INV : C_RD;
              pos_d = '0;
            end
          end
          C_INV: begin
            sq_push = 1'b1;
            sq_char = invalid_char(pos_q);
            if (can_push) begin
              pos_d = pos_q + 4'd1;
              if (pos_q == InvLastPos) sub_d = C_STAR;
            end
          end
          C_RD: begin
            rd_en = 1'b1;
            sub_d = C_CHK;
          end
          C_CHK: begin
            sq_push = ({1'b0, rd_c} != ChSpace);
            sq_char = {1'b0, rd_c};
            if (!sq_push || can_push) begin
              pos_d = pos_q + 4'd1;
              sub_d = (pos_q[2:0] == AddrLastByte - 3'd1) ? C_DASH : C_RD;
            end
          end
          C_DASH: begin
            sq_push = (cs_ssid != 4'd0);
            sq_char = ChDash;
            if (!sq_push) sub_d = C_STAR;
            else if (can_push) sub_d = C_TEN;
          end
          C_TEN: begin
            sq_push = (cs_ssid >= 4'd10);
            sq_char = ChOne;
            if (!sq_push || can_push) sub_d = C_ONE;
          end
          C_ONE: begin
            sq_push = 1'b1;
            sq_char = ChZero + {4'd0, ones};
            if (can_push) sub_d = C_STAR;
          end
          default: begin
            sq_push = cs_star;
            sq_char = ChStar;
            if (!cs_star || can_push) begin
              it_done = 1'b1;
              sub_d   = C_START;
            end
          end
        endcase
      end
    end
  end

  // Address memory write on accept, registered read for the sequencer
  always_ff @(posedge clk_i) begin
    if (accept && a_wr) begin
      mem_q[{cur_p_q, bia_q}] <= in_data_i.data_byte;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Metadata and job payload
  always_ff @(posedge clk_i) begin
    if (accept && !rej_q && phase_q == PH_ADDR) begin
      if (bia_q == 3'd0) begin
        c_bad_q <= !call_char_ok(in_c);
        c_nsp_q <= ({1'b0, in_c} != ChSpace);
      end else if (bia_q != AddrLastByte) begin
        c_bad_q <= c_bad_q | !call_char_ok(in_c);
        c_nsp_q <= c_nsp_q | ({1'b0, in_c} != ChSpace);
      end else if (anum_q == 4'd0) begin
        d_bad_q  <= c_bad_q;
        d_ssid_q <= new_ssid;
      end else if (anum_q != 4'd1 && !last) begin
        p_bad_q  <= c_bad_q;
        p_nsp_q  <= c_nsp_q;
        p_ssid_q <= new_ssid;
        p_h_q    <= cur_h;
      end
    end
    if (accept) begin
      ja_slot_q  <= ja_slot_d;
      jb_slot_q  <= jb_slot_d;
      ja_bad_q   <= ja_bad_d;
      jb_bad_q   <= jb_bad_d;
      ja_ssid_q  <= ja_ssid_d;
      jb_ssid_q  <= jb_ssid_d;
      ja_comma_q <= ja_comma_d;
      jb_comma_q <= jb_comma_d;
      ja_star_q  <= ja_star_d;
      jb_star_q  <= jb_star_d;
    end
  end

  // Control state, sequencer state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_KISS;
      bia_q    <= '0;
      anum_q   <= '0;
      pvalid_q <= 1'b0;
      rej_q    <= 1'b0;
      dst_p_q  <= 2'd0;
      cur_p_q  <= 2'd1;
      pnd_p_q  <= 2'd2;
      todo_q   <= '0;
      sub_q    <= C_START;
      pos_q    <= '0;
      ov_q     <= 1'b0;
      out_q    <= '0;
    end else begin
      if (accept) begin
        phase_q  <= phase_d;
        bia_q    <= bia_d;
        anum_q   <= anum_d;
        pvalid_q <= pvalid_d;
        rej_q    <= rej_d;
        dst_p_q  <= dst_p_d;
        cur_p_q  <= cur_p_d;
        pnd_p_q  <= pnd_p_d;
        todo_q   <= todo_d;
      end else if (it_done) begin
        todo_q <= todo_q & ~low_bit;
      end
      sub_q <= sub_d;
      pos_q <= pos_d;
      if (accept && a_push) begin
        ov_q  <= 1'b1;
        out_q <= a_word;
      end else if (sq_push && can_push) begin
        ov_q           <= 1'b1;
        out_q.out_char <= sq_char;
        out_q.line_end <= sq_le;
        out_q.drop_line <= 1'b0;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // Slot pointers always name three distinct slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dst_p_q != cur_p_q) && (cur_p_q != pnd_p_q) && (dst_p_q != pnd_p_q))
    else $error("address slot pointers collide");

  // A swallowed frame has no burst in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rej_q |-> (todo_q == '0))
    else $error("burst pending while frame is rejected");

  // Memory data is checked only after a read was issued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!idle && is_call && sub_q == C_CHK) |->
      ($past(sub_q) == C_RD || $past(sub_q) == C_CHK))
    else $error("memory data used without a read");

  // A drop word carries no character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_q.drop_line) |-> (out_q.line_end && out_q.out_char == 8'd0))
    else $error("malformed drop word");
`endif

endmodule

// ===== tb/sv/ax25_frame_to_monitor_text_tb.sv =====
// Testbench for the AX.25 frame to monitor text block.
// Drives KISS frame bytes, predicts the monitor text and checks every word.
// Depends on afmt_pkg and ax25_frame_to_monitor_text.
module ax25_frame_to_monitor_text_tb;
  import afmt_pkg::*;

  localparam int MaxDigis = 6;
  localparam int CycleLimit = 400000;
  localparam int TailCycles = 64;

  typedef enum logic [2:0] {
    PhKiss = 3'd0, PhAddr = 3'd1, PhCtrl = 3'd2, PhPid = 3'd3, PhInfo = 3'd4
  } phase_e;

  int err_count = 0;

  // Report one mismatch and count it
  task automatic report(input string msg);
    $display("MISMATCH: %s", msg);
    err_count++;
  endtask

  // Text predictor and store of expected words
  class text_board;
    phase_e    phase;
    bit [2:0]  addr_byte;
    bit [3:0]  addr_num;
    bit [7:0]  dest_addr[7];
    bit [7:0]  cur_addr[7];
    bit [7:0]  pend_addr[7];
    bit        pend_valid;
    bit        rejected;
    out_t      expected_words[$];

    function void clear();
      phase = PhKiss;
      addr_byte = 0;
      addr_num = 0;
      pend_valid = 0;
      rejected = 0;
      expected_words.delete();
    endfunction

    function void push_char(ref out_t buf_q[$], input bit [7:0] c);
      out_t w;
      w.out_char = c;
      w.line_end = 1'b0;
      w.drop_line = 1'b0;
      buf_q.push_back(w);
    endfunction

    // Decode one address into characters
    function void call_chars(input bit [7:0] a[7], ref bit [7:0] txt[$]);
      bit [6:0] c;
      bit [3:0] ssid;
      string bad;
      txt.delete();
      bad = "[invalid]";
      for (int i = 0; i < 6; i++) begin
        c = a[i][7:1];
        if (!((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
              (c >= "a" && c <= "z") || c == " ")) begin
          txt.delete();
          for (int k = 0; k < 9; k++) txt.push_back(bad[k]);
          return;
        end
        if (c != " ") txt.push_back({1'b0, c});
      end
      ssid = a[6][4:1];
      if (ssid != 0) begin
        txt.push_back("-");
        if (ssid >= 10) begin
          txt.push_back("1");
          ssid -= 10;
        end
        txt.push_back(8'h30 + ssid);
      end
    endfunction

    function void add_call(ref out_t buf_q[$], input bit [7:0] a[7]);
      bit [7:0] txt[$];
      call_chars(a, txt);
      foreach (txt[i]) push_char(buf_q, txt[i]);
    endfunction

    function void add_repeater(ref out_t buf_q[$], input bit [7:0] a[7], input bit star);
      bit [7:0] txt[$];
      call_chars(a, txt);
      if (txt.size() == 0) return;
      push_char(buf_q, ChComma);
      foreach (txt[i]) push_char(buf_q, txt[i]);
      if (star) push_char(buf_q, ChStar);
    endfunction

    // Note an accepted input word and predict its output words
    function void note_input(input in_t w);
      out_t step_q[$];
      out_t d;
      bit [7:0] b;
      bit fe, reject, done, last, cur_h, ph;
      b = w.data_byte;
      fe = w.frame_end;
      reject = 0;
      done = 0;
      if (rejected) begin
        if (fe) begin
          rejected = 0;
          phase = PhKiss;
        end
        return;
      end
      case (phase)
        PhKiss: begin
          if ((b[3:0] & KissTypeMask) != 0) reject = 1;
          else begin
            phase = PhAddr;
            addr_byte = 0;
            addr_num = 0;
            pend_valid = 0;
          end
        end
        PhAddr: begin
          cur_addr[addr_byte] = b;
          if (addr_byte < 6) addr_byte++;
          else begin
            last = b[0];
            addr_byte = 0;
            if (addr_num == 0) begin
              dest_addr = cur_addr;
              addr_num = 1;
            end else if (addr_num == 1) begin
              if (!last && MaxDigis == 0) reject = 1;
              else begin
                add_call(step_q, cur_addr);
                push_char(step_q, ChGt);
                add_call(step_q, dest_addr);
                if (last) phase = PhCtrl;
                else addr_num = 2;
              end
            end else begin
              cur_h = cur_addr[6][7];
              if (!last && (addr_num - 1) >= MaxDigis) reject = 1;
              else begin
                if (pend_valid) begin
                  ph = pend_addr[6][7];
                  add_repeater(step_q, pend_addr, ph && !cur_h);
                end
                if (last) begin
                  add_repeater(step_q, cur_addr, cur_h);
                  pend_valid = 0;
                  phase = PhCtrl;
                end else begin
                  pend_addr = cur_addr;
                  pend_valid = 1;
                  addr_num = addr_num + 1;
                end
              end
            end
          end
        end
        PhCtrl: begin
          if (b != CtrlUi) reject = 1;
          else phase = PhPid;
        end
        PhPid: begin
          if (b != PidNone) reject = 1;
          else begin
            push_char(step_q, ChColon);
            phase = PhInfo;
            if (fe) done = 1;
          end
        end
        default: begin
          push_char(step_q, (b >= ChSpace && b <= ChTilde) ? b : ChSpace);
          if (fe) done = 1;
        end
      endcase
      if (!reject && fe && !done) reject = 1;
      if (reject) begin
        d.out_char = 8'h00;
        d.line_end = 1'b1;
        d.drop_line = 1'b1;
        expected_words.push_back(d);
        pend_valid = 0;
        addr_byte = 0;
        addr_num = 0;
        phase = PhKiss;
        rejected = !fe;
        return;
      end
      if (done) begin
        push_char(step_q, ChCr);
        d.out_char = ChLf;
        d.line_end = 1'b1;
        d.drop_line = 1'b0;
        step_q.push_back(d);
        phase = PhKiss;
        addr_byte = 0;
        addr_num = 0;
        pend_valid = 0;
      end
      foreach (step_q[i]) expected_words.push_back(step_q[i]);
    endfunction

    // Check one accepted output word against the oldest expectation
    task check_output(input out_t got);
      out_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word char=%h le=%b drop=%b",
                         got.out_char, got.line_end, got.drop_line));
        return;
      end
      want = expected_words.pop_front();
      if (got.out_char !== want.out_char)
        report($sformatf("out_char %h, want %h", got.out_char, want.out_char));
      if (got.line_end !== want.line_end)
        report($sformatf("line_end %b, want %b", got.line_end, want.line_end));
      if (got.drop_line !== want.drop_line)
        report($sformatf("drop_line %b, want %b", got.drop_line, want.drop_line));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  text_board board = new();
  int   cycle_count = 0;
  int   sent_count = 0;
  bit   hold_sink = 0;
  bit   sink_idle = 1;
  bit [7:0] frame_q[$];

  ax25_frame_to_monitor_text #(.MAX_DIGIS(MaxDigis)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // Bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("ax25_frame_to_monitor_text regression: fail");
      $finish;
    end
  end

  // Sample output words
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_output(out_data_o);
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Sink stall pattern
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_sink) out_ready_i <= 1'b0;
      else if (sink_idle) out_ready_i <= 1'b1;
      else begin
        g = gap_len();
        if (g == 0) out_ready_i <= 1'b1;
        else begin
          out_ready_i <= 1'b0;
          repeat (g - 1) @(posedge clk_i);
        end
      end
    end
  end

  // Send one input word and wait for acceptance
  task automatic send_word(input bit [7:0] b, input bit fe, input bit gaps);
    in_t w;
    int g;
    if (gaps) begin
      g = gap_len();
      if (g > 0) begin
        in_valid_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
    w.data_byte = b;
    w.frame_end = fe;
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_input(w);
    sent_count++;
  endtask

  task automatic send_frame(input bit gaps);
    foreach (frame_q[i]) send_word(frame_q[i], i == frame_q.size() - 1, gaps);
    frame_q.delete();
  endtask

  function automatic bit [7:0] rand_call_char();
    bit [7:0] set_chars;
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) set_chars = 8'h41 + 8'($urandom_range(0, 25));
    else if (r < 7) set_chars = 8'h30 + 8'($urandom_range(0, 9));
    else if (r < 8) set_chars = 8'h61 + 8'($urandom_range(0, 25));
    else set_chars = ChSpace;
    return set_chars;
  endfunction

  // Append one address: kind 0 plain, 1 blank, 2 may hold an invalid char
  task automatic add_address(input int kind, input bit last, input bit hbit);
    bit [7:0] c;
    for (int i = 0; i < 6; i++) begin
      if (kind == 1) c = ChSpace;
      else c = rand_call_char();
      if (kind == 2 && i == $urandom_range(0, 5)) c = 8'h21;
      frame_q.push_back({c[6:0], 1'($urandom_range(0, 1))});
    end
    frame_q.push_back({hbit, 2'($urandom_range(0, 3)),
                       (kind == 1) ? 4'd0 : 4'($urandom_range(0, 15)), last});
  endtask

  task automatic build_frame(input int digis, input int info_len, input int mode);
    frame_q.push_back({4'($urandom_range(0, 15)), 4'h0});
    add_address($urandom_range(0, 9) == 0 ? 2 : 0, 1'b0, 1'($urandom_range(0, 1)));
    add_address($urandom_range(0, 9) == 0 ? 1 : 0, digis == 0, 1'($urandom_range(0, 1)));
    for (int d = 0; d < digis; d++)
      add_address($urandom_range(0, 5) == 0 ? 1 : ($urandom_range(0, 9) == 0 ? 2 : 0),
                  d == digis - 1, 1'($urandom_range(0, 1)));
    frame_q.push_back((mode == 1) ? 8'($urandom_range(0, 255)) : CtrlUi);
    frame_q.push_back((mode == 2) ? 8'($urandom_range(0, 255)) : PidNone);
    for (int i = 0; i < info_len; i++) frame_q.push_back(8'($urandom_range(0, 255)));
    if (mode == 3) frame_q = frame_q[0:$urandom_range(0, frame_q.size() - 2)];
  endtask

  task automatic drain();
    while (board.expected_words.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int mode;
    board.clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: good frame with info extremes
    build_frame(2, 4, 0);
    frame_q[$-3] = 8'h00; frame_q[$-2] = 8'hFF;
    frame_q[$-1] = ChSpace; frame_q[$] = ChTilde;
    send_frame(0);
    // Bad KISS type, then bad control, bad PID, truncated
    frame_q = '{8'h0F, 8'h00, 8'h80};
    send_frame(0);
    build_frame(0, 0, 1); send_frame(0);
    build_frame(0, 1, 2); send_frame(0);
    frame_q = '{8'h00, 8'hFE, 8'h01};
    send_frame(0);
    // Too many repeaters, ended one byte after the rejecting address
    build_frame(7, 0, 0);
    frame_q = frame_q[0:57];
    send_frame(0);
    // Exactly the maximum
    build_frame(MaxDigis, 0, 0); send_frame(0);
    sink_idle = 0;

    // Sink holds off while the source keeps offering
    fork
      begin
        hold_sink = 1;
        repeat (300) @(posedge clk_i);
        hold_sink = 0;
      end
      begin
        build_frame(2, 6, 0);
        send_frame(0);
      end
    join
    // Source pauses until everything has drained
    in_valid_i <= 1'b0;
    drain();

    while (sent_count < 160) begin
      mode = $urandom_range(0, 9);
      mode = (mode < 7) ? 0 : mode - 6;
      build_frame($urandom_range(0, 7) == 0 ? $urandom_range(0, 8) : $urandom_range(0, 3),
                  $urandom_range(0, 6), mode);
      send_frame(1);
    end
    in_valid_i <= 1'b0;
    drain();
    repeat (TailCycles) @(posedge clk_i);
    if (err_count == 0 && board.expected_words.size() == 0)
      $display("ax25_frame_to_monitor_text regression: pass");
    else
      $display("ax25_frame_to_monitor_text regression: fail");
    $finish;
  end
endmodule

// ===== sim.f =====
src/afmt_pkg.sv
src/ax25_frame_to_monitor_text.sv
tb/sv/ax25_frame_to_monitor_text_tb.sv
